[rtl/ohm_pkg.sv]
// ----------------------------------------------------------------------------
// ohm_pkg
// Shared types and constants for the omni drive heading mixer: wheel command
// codes, the twelve-direction mixing table, fixed-point constants and the
// item format that travels between the front and back parts.
// ----------------------------------------------------------------------------
package ohm_pkg;

    localparam int DIR_W     = 4;
    localparam int POWER_W   = 8;
    localparam int HEADING_W = 12;
    localparam int BATT_W    = 10;
    localparam int DUTY_W    = 8;
    localparam int WHEEL_W   = 9;   // corrected wheel value, signed
    localparam int NUM_WHEELS = 3;

    localparam int S_TDATA_W = 40;  // 34 bits of fields, padded to bytes
    localparam int M_TDATA_W = 32;  // 28 bits of fields, padded to bytes

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [DIR_W-1:0]  NUM_DIRS      = 4'd12;
    localparam logic [BATT_W-1:0] THRESHOLD_RST = 10'd95;

    // floor(h / 10) == (h * 52429) >> 19 for every 12-bit h
    localparam logic [15:0] TENTH_RECIP = 16'd52429;
    localparam int          TENTH_SHIFT = 19;
    localparam logic signed [9:0] HEADING_CENTER = 10'sd180;

    // floor(m * 255 / 100) == (m * 167117) >> 16 for every m below 3276
    localparam logic [17:0] DUTY_RECIP = 18'd167117;
    localparam int          DUTY_SHIFT = 16;
    localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;

    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_POS      = 3'd1,
        CMD_NEG      = 3'd2,
        CMD_HALF_POS = 3'd3,
        CMD_HALF_NEG = 3'd4
    } cmd_code_t;

    // rows: directions 0..11, columns: wheels A, B, C
    localparam cmd_code_t MIX_TABLE [12][3] = '{
        '{CMD_POS,      CMD_NONE,     CMD_NEG     },
        '{CMD_HALF_POS, CMD_HALF_POS, CMD_NEG     },
        '{CMD_NONE,     CMD_POS,      CMD_NEG     },
        '{CMD_HALF_NEG, CMD_POS,      CMD_HALF_NEG},
        '{CMD_NEG,      CMD_POS,      CMD_NONE    },
        '{CMD_NEG,      CMD_HALF_POS, CMD_HALF_POS},
        '{CMD_NEG,      CMD_NONE,     CMD_POS     },
        '{CMD_HALF_NEG, CMD_HALF_NEG, CMD_POS     },
        '{CMD_NONE,     CMD_NEG,      CMD_POS     },
        '{CMD_HALF_POS, CMD_NEG,      CMD_HALF_POS},
        '{CMD_POS,      CMD_NEG,      CMD_NONE    },
        '{CMD_POS,      CMD_HALF_NEG, CMD_HALF_NEG}
    };

    // classified item, handed from front to back through the queue
    typedef struct packed {
        logic                      batt_low;
        logic signed [WHEEL_W-1:0] wheel_c;
        logic signed [WHEEL_W-1:0] wheel_b;
        logic signed [WHEEL_W-1:0] wheel_a;
    } item_t;

endpackage

[rtl/ohm_front.sv]
// ----------------------------------------------------------------------------
// ohm_front
// Accepts input items, drops ignored directions, checks the battery against
// the threshold register and computes the three heading-corrected wheel values.
// ----------------------------------------------------------------------------
module ohm_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ohm_pkg::BATT_W-1:0]     cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ohm_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           q_ready,
    output logic                           q_push,
    output ohm_pkg::item_t                 q_item
);

    logic [ohm_pkg::BATT_W-1:0]    threshold_reg;
    logic [ohm_pkg::BATT_W-1:0]    threshold_next;

    logic [ohm_pkg::DIR_W-1:0]     dir;
    logic signed [ohm_pkg::POWER_W-1:0] pwr;
    logic [ohm_pkg::HEADING_W-1:0] hdg;
    logic [ohm_pkg::BATT_W-1:0]    batt;

    logic signed [8:0]  p9;
    logic signed [8:0]  half9;
    logic [27:0]        hdg_prod;
    logic [8:0]         hdg_deg;
    logic signed [9:0]  offset;
    logic signed [ohm_pkg::WHEEL_W-1:0] wheel [ohm_pkg::NUM_WHEELS];

    // field order, low bits first: direction, power, heading, battery_level
    assign dir  = s_tdata[3:0];
    assign pwr  = s_tdata[11:4];
    assign hdg  = s_tdata[23:12];
    assign batt = s_tdata[33:24];

    assign threshold_next = cfg_wr_en ? cfg_wr_data : threshold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= ohm_pkg::THRESHOLD_RST;
        end else begin
            threshold_reg <= threshold_next;
        end
    end

    function automatic ohm_pkg::cmd_code_t mix_lookup(input logic [3:0] d, input int k);
        ohm_pkg::cmd_code_t code;
        code = ohm_pkg::CMD_NONE;
        if (d < ohm_pkg::NUM_DIRS) begin
            code = ohm_pkg::MIX_TABLE[d][k];
        end
        return code;
    endfunction

    // half power truncates toward zero
    assign p9    = {pwr[7], pwr};
    assign half9 = (p9 + $signed({8'd0, pwr[7]})) >>> 1;

    assign hdg_prod = 28'(hdg) * 28'(ohm_pkg::TENTH_RECIP);
    assign hdg_deg  = hdg_prod[27:ohm_pkg::TENTH_SHIFT];
    assign offset   = $signed({1'b0, hdg_deg}) - ohm_pkg::HEADING_CENTER;

    always_comb begin
        for (int k = 0; k < ohm_pkg::NUM_WHEELS; k++) begin
            logic signed [8:0]  cmd;
            logic signed [10:0] sum;
            logic signed [10:0] halved;
            unique case (mix_lookup(dir, k))
                ohm_pkg::CMD_POS:      cmd = p9;
                ohm_pkg::CMD_NEG:      cmd = -p9;
                ohm_pkg::CMD_HALF_POS: cmd = half9;
                ohm_pkg::CMD_HALF_NEG: cmd = -half9;
                default:               cmd = 9'sd0;
            endcase
            // (2*cmd + offset) / 2, truncated toward zero
            sum      = $signed({cmd[8], cmd, 1'b0}) + $signed({offset[9], offset});
            halved   = (sum + $signed({10'd0, sum[10]})) >>> 1;
            wheel[k] = halved[ohm_pkg::WHEEL_W-1:0];
        end
    end

    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready && (dir < ohm_pkg::NUM_DIRS);

    assign q_item.batt_low = (batt < threshold_reg);
    assign q_item.wheel_a  = wheel[0];
    assign q_item.wheel_b  = wheel[1];
    assign q_item.wheel_c  = wheel[2];

endmodule

[rtl/ohm_queue.sv]
// ----------------------------------------------------------------------------
// ohm_queue
// Short FIFO of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module ohm_queue #(
    parameter int QUEUE_DEPTH = ohm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  ohm_pkg::item_t push_item,
    output logic           ready,
    input  logic           pop,
    output logic           valid,
    output ohm_pkg::item_t pop_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    ohm_pkg::item_t   entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push, do_pop;

    assign ready    = (count_reg != CNT_FULL);
    assign valid    = (count_reg != '0);
    assign pop_item = entry_reg[rd_ptr_reg];
    assign do_push  = push && ready;
    assign do_pop   = pop && valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("queue count above depth");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

endmodule

[rtl/ohm_back.sv]
// ----------------------------------------------------------------------------
// ohm_back
// Pops classified items, applies the battery fault latch, scales each wheel
// to a saturated PWM duty and holds the result in the output register.
// ----------------------------------------------------------------------------
module ohm_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    input  ohm_pkg::item_t                 q_item,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ohm_pkg::M_TDATA_W-1:0]  m_tdata
);

    logic                  fault_reg,   fault_next;
    logic [2:0]            held_rev_reg, held_rev_next;
    logic                  out_valid_reg, out_valid_next;
    logic [ohm_pkg::DUTY_W-1:0] duty_reg [ohm_pkg::NUM_WHEELS];
    logic [ohm_pkg::DUTY_W-1:0] duty_next [ohm_pkg::NUM_WHEELS];
    logic [2:0]            rev_reg, rev_next;
    logic                  flt_out_reg, flt_out_next;

    logic signed [ohm_pkg::WHEEL_W-1:0] wheel [ohm_pkg::NUM_WHEELS];
    logic [ohm_pkg::DUTY_W-1:0] scaled [ohm_pkg::NUM_WHEELS];
    logic [2:0]            neg_bits;
    logic                  faulted;

    assign wheel[0] = q_item.wheel_a;
    assign wheel[1] = q_item.wheel_b;
    assign wheel[2] = q_item.wheel_c;

    assign q_pop = q_valid && (!out_valid_reg || m_tready);

    always_comb begin
        for (int k = 0; k < ohm_pkg::NUM_WHEELS; k++) begin
            logic [7:0]  mag;
            logic [25:0] prod;
            logic [9:0]  d;
            mag  = wheel[k][ohm_pkg::WHEEL_W-1] ? 8'(-wheel[k]) : 8'(wheel[k]);
            prod = 26'(mag) * 26'(ohm_pkg::DUTY_RECIP);
            d    = prod[25:ohm_pkg::DUTY_SHIFT];
            scaled[k]   = (d > 10'(ohm_pkg::DUTY_MAX)) ? ohm_pkg::DUTY_MAX : d[7:0];
            neg_bits[k] = wheel[k][ohm_pkg::WHEEL_W-1];
        end
    end

    // fault is checked before any wheel update and clears only on reset
    assign faulted = fault_reg || q_item.batt_low;

    always_comb begin
        fault_next     = fault_reg;
        held_rev_next  = held_rev_reg;
        out_valid_next = out_valid_reg;
        duty_next      = duty_reg;
        rev_next       = rev_reg;
        flt_out_next   = flt_out_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (q_pop) begin
            out_valid_next = 1'b1;
            fault_next     = faulted;
            flt_out_next   = faulted;
            if (faulted) begin
                for (int k = 0; k < ohm_pkg::NUM_WHEELS; k++) begin
                    duty_next[k] = '0;
                end
                rev_next = held_rev_reg;
            end else begin
                duty_next     = scaled;
                rev_next      = neg_bits;
                held_rev_next = neg_bits;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fault_reg     <= 1'b0;
            held_rev_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            fault_reg     <= fault_next;
            held_rev_reg  <= held_rev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        duty_reg    <= duty_next;
        rev_reg     <= rev_next;
        flt_out_reg <= flt_out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, flt_out_reg, rev_reg, duty_reg[2], duty_reg[1], duty_reg[0]};

    a_fault_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        fault_reg |=> fault_reg)
        else $error("battery fault cleared without reset");

    a_fault_zero_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && flt_out_reg) |->
            (duty_reg[0] == '0 && duty_reg[1] == '0 && duty_reg[2] == '0))
        else $error("nonzero duty while faulted");

    a_fault_rev_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && fault_reg) |=> (rev_reg == held_rev_reg))
        else $error("reverse bits changed while faulted");

endmodule

[rtl/omni_drive_heading_mixer.sv]
// ----------------------------------------------------------------------------
// omni_drive_heading_mixer
// Three-wheel omni drive mixer with compass heading correction and a
// latched low-battery cutoff.
//
//   channel   dir  handshake           payload
//   s_*       in   s_tvalid/s_tready   direction, power, heading, battery_level
//   m_*       out  m_tvalid/m_tready   duty_a..c, reverse_a..c, battery_fault
//   cfg_*     in   cfg_wr_en           low_battery_threshold
//
// One item per cycle sustained while m_tready stays high. With the queue empty,
// an accepted item is written to a queue entry, then to the output register,
// which raises m_tvalid. Front and back are split by a QUEUE_DEPTH-entry FIFO,
// so the input takes up to QUEUE_DEPTH more items while a result waits.
// Directions 12..15 are accepted and dropped. Reset clears the queue, the
// fault latch and the held reverse bits, and loads the threshold with 95.
// ----------------------------------------------------------------------------
module omni_drive_heading_mixer #(
    parameter int QUEUE_DEPTH = ohm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ohm_pkg::BATT_W-1:0]     cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // direction[3:0], power[11:4], heading[23:12], battery_level[33:24]
    input  logic [ohm_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // duty_a[7:0], duty_b[15:8], duty_c[23:16], reverse_a[24], reverse_b[25],
    // reverse_c[26], battery_fault[27]
    output logic [ohm_pkg::M_TDATA_W-1:0]  m_tdata
);

    logic           q_ready;
    logic           q_push;
    ohm_pkg::item_t q_in_item;
    logic           q_valid;
    logic           q_pop;
    ohm_pkg::item_t q_out_item;

    ohm_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .q_ready     (q_ready),
        .q_push      (q_push),
        .q_item      (q_in_item)
    );

    ohm_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in_item),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_item  (q_out_item)
    );

    ohm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_out_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
